[rtl/core/cpsb_pkg.sv]
// ---------------------------------------------------------------------------
// cpsb_pkg: shared types and helpers for the complex power spectrum unit
// Single-precision constants, leading-zero count and round-to-nearest-even
// packing used by the squaring and summing pipelines.
// ---------------------------------------------------------------------------
package cpsb_pkg;

  localparam logic [31:0] QNAN_WORD = 32'h7FC0_0000;
  localparam logic [31:0] INF_WORD  = 32'h7F80_0000;
  localparam logic [7:0]  EXP_MAX   = 8'hFF;

  // Operand class flags carried alongside a word.
  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
  } fclass_t;

  // Leading zeros of a 24-bit significand (24 when it is zero).
  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] n;
    logic       found;
    n     = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && m[i]) begin
        n     = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Round a positive value to nearest even and pack it.
  // exp_in is the biased exponent (0 for subnormal), sig has its hidden bit
  // at bit 23; r and s are the round and sticky bits.
  function automatic logic [31:0] round_pack(input logic [8:0] exp_in,
                                             input logic [23:0] sig,
                                             input logic r, input logic s);
    logic        inc;
    logic [24:0] sum;
    logic [8:0]  e;
    logic [22:0] frac;
    inc  = r & (s | sig[0]);
    sum  = {1'b0, sig} + {24'd0, inc};
    e    = exp_in;
    frac = sum[22:0];
    if (sum[24]) begin
      e    = exp_in + 9'd1;
      frac = sum[23:1];
    end else if (exp_in == 9'd0 && sum[23]) begin
      e = 9'd1;
    end
    if (e >= 9'd255) begin
      return INF_WORD;
    end
    return {1'b0, e[7:0], frac};
  endfunction

endpackage

[rtl/core/cpsb_square.sv]
// ---------------------------------------------------------------------------
// cpsb_square: four-stage single-precision squarer
// Normalizes the operand, multiplies the significands, aligns the product
// (including subnormal results) and rounds to nearest even.
// ---------------------------------------------------------------------------
module cpsb_square import cpsb_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x,
  output logic [31:0] sq
);

  // Stage A: classify and normalize the significand.
  fclass_t           cls_a;
  logic [23:0]       m_a;
  logic signed [9:0] e_a;

  // Stage B: significand product.
  fclass_t           cls_b;
  logic [47:0]       p_b;
  logic signed [9:0] e_b;

  // Stage C: aligned significand with round and sticky bits.
  fclass_t           cls_c;
  logic [8:0]        exp_c;
  logic [23:0]       sig_c;
  logic              r_c;
  logic              s_c;

  logic [7:0]         x_exp;
  logic [23:0]        x_man;
  logic [4:0]         x_lz;
  logic [7:0]         x_eeff;
  logic [47:0]        q;
  logic signed [10:0] bv;
  logic signed [10:0] sh_wide;
  logic [5:0]         sh;
  logic [111:0]       wide;

  assign x_exp  = x[30:23];
  assign x_man  = {x_exp != 8'd0, x[22:0]};
  assign x_lz   = lzc24(x_man);
  assign x_eeff = (x_exp == 8'd0) ? 8'd1 : x_exp;

  always_ff @(posedge clk) begin
    if (en) begin
      cls_a.nan  <= (x_exp == EXP_MAX) && (x[22:0] != 23'd0);
      cls_a.inf  <= (x_exp == EXP_MAX) && (x[22:0] == 23'd0);
      cls_a.zero <= (x[30:0] == 31'd0);
      m_a        <= x_man << x_lz;
      e_a        <= $signed({2'b00, x_eeff}) - $signed({5'd0, x_lz});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_b <= cls_a;
      p_b   <= m_a * m_a;
      e_b   <= e_a;
    end
  end

  // Product sits at bit 47 or 46; small exponents shift into a subnormal.
  always_comb begin
    q       = p_b[47] ? p_b : {p_b[46:0], 1'b0};
    bv      = $signed({e_b, 1'b0}) - 11'sd126 - (p_b[47] ? 11'sd0 : 11'sd1);
    sh_wide = 11'sd1 - bv;
    if (bv >= 11'sd1) begin
      sh = 6'd0;
    end else if (sh_wide > 11'sd63) begin
      sh = 6'd63;
    end else begin
      sh = sh_wide[5:0];
    end
    wide = {q, 64'd0} >> sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_c <= cls_b;
      if (bv > 11'sd254) begin
        exp_c <= 9'd255;
      end else if (bv >= 11'sd1) begin
        exp_c <= bv[8:0];
      end else begin
        exp_c <= 9'd0;
      end
      sig_c <= wide[111:88];
      r_c   <= wide[87];
      s_c   <= |wide[86:0];
    end
  end

  // Stage D: round and apply special operands.
  always_ff @(posedge clk) begin
    if (en) begin
      if (cls_c.nan) begin
        sq <= QNAN_WORD;
      end else if (cls_c.inf) begin
        sq <= INF_WORD;
      end else if (cls_c.zero) begin
        sq <= 32'd0;
      end else begin
        sq <= round_pack(exp_c, sig_c, r_c, s_c);
      end
    end
  end

endmodule

[rtl/core/complex_power_spectrum_bins_unit.sv]
// ---------------------------------------------------------------------------
// complex_power_spectrum_bins_unit: power of complex FFT bins
// Computes real*real + imag*imag in single precision with separate rounding
// of each product and the sum, and keeps the first bins of every frame.
// ---------------------------------------------------------------------------
// Usage:
// The bin channel (bin_valid/bin_ready) takes one word per cycle holding
// real_part and imag_part as single-precision bit patterns. The power
// channel (power_valid/power_ready) returns power_value and frame_end.
// A bin counter walks each frame of FRAME_LENGTH words; only the first
// KEPT_BINS words of a frame return a result, and frame_end marks the last
// kept bin. The other words are taken and dropped, advancing the counter.
// Throughput is one word per cycle unless power_ready stalls the output; the
// input register and the eight stages behind it (decode, multiply, align,
// round, order, shift, add, round) move forward as one pipeline.
// When power_ready is low with a result waiting, all stages hold and
// bin_ready drops in the same cycle. Reset clears the counter and all valid
// bits; no result is pending afterwards.
// ---------------------------------------------------------------------------
module complex_power_spectrum_bins_unit import cpsb_pkg::*; #(
  parameter int FRAME_LENGTH = 1024,
  parameter int KEPT_BINS    = 513
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        bin_valid,
  output logic        bin_ready,
  input  logic [31:0] real_part,
  input  logic [31:0] imag_part,
  output logic        power_valid,
  input  logic        power_ready,
  output logic [31:0] power_value,
  output logic        frame_end
);

  localparam int CW     = $clog2(FRAME_LENGTH);
  localparam int STAGES = 8;

  logic [CW-1:0] bin_index;
  logic [16:0]   bin_ext;
  logic          keep;
  logic          last;
  logic          adv;
  logic          take;

  // Valid and frame-end flags for stages 1 to 8; stage 9 is the output.
  logic [STAGES:1] vld;
  logic [STAGES:1] lst;

  logic [31:0] re1;
  logic [31:0] im1;
  logic [31:0] sq_re;
  logic [31:0] sq_im;

  assign adv       = !power_valid || power_ready;
  assign bin_ready = adv;
  assign take      = bin_valid && bin_ready;
  assign bin_ext   = 17'(bin_index);
  assign keep      = bin_ext < 17'(KEPT_BINS);
  assign last      = bin_ext == 17'(KEPT_BINS - 1);

  // Bin counter over the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_index <= '0;
    end else if (take) begin
      if (bin_index == CW'(FRAME_LENGTH - 1)) begin
        bin_index <= '0;
      end else begin
        bin_index <= bin_index + CW'(1);
      end
    end
  end

  // Control flags travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      lst <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-1:1], take && keep};
      lst <= {lst[STAGES-1:1], take && keep && last};
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (adv) begin
      re1 <= real_part;
      im1 <= imag_part;
    end
  end

  cpsb_square u_sq_re (.clk(clk), .en(adv), .x(re1), .sq(sq_re));
  cpsb_square u_sq_im (.clk(clk), .en(adv), .x(im1), .sq(sq_im));

  // Order stage: larger square first, exponent distance.
  logic       a_ge_b;
  logic [7:0] ea_eff;
  logic [7:0] eb_eff;
  logic [7:0] edist;
  fclass_t    cls6;
  logic [7:0] eb6;
  logic [23:0] bsig6;
  logic [23:0] ssig6;
  logic [4:0]  dist6;

  assign a_ge_b = sq_re[30:0] >= sq_im[30:0];
  assign ea_eff = (sq_re[30:23] == 8'd0) ? 8'd1 : sq_re[30:23];
  assign eb_eff = (sq_im[30:23] == 8'd0) ? 8'd1 : sq_im[30:23];
  assign edist  = a_ge_b ? (ea_eff - eb_eff) : (eb_eff - ea_eff);

  always_ff @(posedge clk) begin
    if (adv) begin
      cls6.nan  <= (sq_re == QNAN_WORD) || (sq_im == QNAN_WORD);
      cls6.inf  <= (sq_re == INF_WORD) || (sq_im == INF_WORD);
      cls6.zero <= 1'b0;
      if (a_ge_b) begin
        eb6   <= sq_re[30:23];
        bsig6 <= {sq_re[30:23] != 8'd0, sq_re[22:0]};
        ssig6 <= {sq_im[30:23] != 8'd0, sq_im[22:0]};
      end else begin
        eb6   <= sq_im[30:23];
        bsig6 <= {sq_im[30:23] != 8'd0, sq_im[22:0]};
        ssig6 <= {sq_re[30:23] != 8'd0, sq_re[22:0]};
      end
      dist6 <= (edist > 8'd31) ? 5'd31 : edist[4:0];
    end
  end

  // Align stage: shift the smaller significand, keep a sticky bit.
  logic [55:0] ext;
  fclass_t     cls7;
  logic [7:0]  eb7;
  logic [25:0] big7;
  logic [25:0] al7;
  logic        stk7;

  assign ext = {ssig6, 32'd0} >> dist6;

  always_ff @(posedge clk) begin
    if (adv) begin
      cls7 <= cls6;
      eb7  <= eb6;
      big7 <= {bsig6, 2'b00};
      al7  <= ext[55:30];
      stk7 <= |ext[29:0];
    end
  end

  // Add stage: both terms are non-negative, so at most one right shift.
  logic [26:0] sum;
  logic [8:0]  eeff7;
  fclass_t     cls8;
  logic [8:0]  exp8;
  logic [23:0] sig8;
  logic        r8;
  logic        s8;

  assign sum   = {1'b0, big7} + {1'b0, al7};
  assign eeff7 = (eb7 == 8'd0) ? 9'd1 : {1'b0, eb7};

  always_ff @(posedge clk) begin
    if (adv) begin
      cls8 <= cls7;
      if (sum[26]) begin
        exp8 <= eeff7 + 9'd1;
        sig8 <= sum[26:3];
        r8   <= sum[2];
        s8   <= sum[1] | sum[0] | stk7;
      end else begin
        exp8 <= sum[25] ? eeff7 : 9'd0;
        sig8 <= sum[25:2];
        r8   <= sum[1];
        s8   <= sum[0] | stk7;
      end
    end
  end

  // Output register: final rounding and special results.
  always_ff @(posedge clk) begin
    if (rst) begin
      power_valid <= 1'b0;
      frame_end   <= 1'b0;
    end else if (adv) begin
      power_valid <= vld[STAGES];
      frame_end   <= lst[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cls8.nan) begin
        power_value <= QNAN_WORD;
      end else if (cls8.inf) begin
        power_value <= INF_WORD;
      end else begin
        power_value <= round_pack(exp8, sig8, r8, s8);
      end
    end
  end

  // The counter stays inside the frame.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    bin_index <= CW'(FRAME_LENGTH - 1))
    else $error("bin index beyond frame length");

  // The last bin of a frame wraps the counter.
  a_index_wrap: assert property (@(posedge clk) disable iff (rst)
    (take && bin_index == CW'(FRAME_LENGTH - 1)) |=> bin_index == '0)
    else $error("bin index did not wrap");

  // A frame marker only travels with a kept result.
  a_mark_valid: assert property (@(posedge clk) disable iff (rst)
    frame_end |-> power_valid)
    else $error("frame_end without a result");

  // A stalled result keeps its frame marker.
  a_mark_hold: assert property (@(posedge clk) disable iff (rst)
    (power_valid && !power_ready) |=> $stable(frame_end) && $stable(power_value))
    else $error("stalled result changed");

endmodule

[verif/tb_complex_power_spectrum_bins_unit.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_complex_power_spectrum_bins_unit: self-checking bench for the power unit
// Drives complex bins as single-precision words in bursts and stalls the
// result side. Every kept bin is predicted by an independent single-precision
// square-and-add model, which rounds through double precision with explicit
// nearest-even rounding. Results are checked in order, field by field.
// ---------------------------------------------------------------------------
module tb_complex_power_spectrum_bins_unit;
  import cpsb_pkg::*;

  localparam int FRAME_LEN   = 1024;
  localparam int KEPT        = 513;
  localparam int RAND_WORDS  = 1100;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct {
    logic [31:0] power_value;
    logic        frame_end;
  } power_word_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        known;
    logic [31:0] power_value;
  } bin_row_t;

  logic        clk;
  logic        rst;
  logic        bin_valid;
  logic        bin_ready;
  logic [31:0] real_part;
  logic [31:0] imag_part;
  logic        power_valid;
  logic        power_ready;
  logic [31:0] power_value;
  logic        frame_end;

  power_word_t power_queue[$];
  int          bin_count;
  int          error_count;
  int          idle_cycles;

  complex_power_spectrum_bins_unit #(
    .FRAME_LENGTH(FRAME_LEN),
    .KEPT_BINS(KEPT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .bin_valid(bin_valid),
    .bin_ready(bin_ready),
    .real_part(real_part),
    .imag_part(imag_part),
    .power_valid(power_valid),
    .power_ready(power_ready),
    .power_value(power_value),
    .frame_end(frame_end)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Widen a single-precision word to a double; every single is exact there.
  function automatic real single_to_double(input logic [31:0] w);
    logic [23:0] m;
    int          e2;
    if (w[30:23] == EXP_MAX) begin
      if (w[22:0] != 0) return $bitstoreal({1'b0, 11'h7FF, 1'b1, 51'd0});
      return $bitstoreal({w[31], 11'h7FF, 52'd0});
    end
    if (w[30:0] == 0) return 0.0;
    if (w[30:23] == 0) begin
      m  = {1'b0, w[22:0]};
      e2 = -126;
      while (!m[23]) begin
        m  = m << 1;
        e2 = e2 - 1;
      end
    end else begin
      m  = {1'b1, w[22:0]};
      e2 = int'(w[30:23]) - 127;
    end
    return $bitstoreal({w[31], 11'(e2 + 1023), m[22:0], 29'd0});
  endfunction

  // Narrow a double to single precision, nearest even, keeping subnormals.
  // NaN of any kind becomes the canonical quiet NaN.
  function automatic logic [31:0] double_to_single(input real x);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    int          es;
    int          sh;
    d = $realtobits(x);
    if (d[62:52] == 11'h7FF) begin
      if (d[51:0] != 0) return QNAN_WORD;
      return {d[63], INF_WORD[30:0]};
    end
    if (d[62:52] == 0) return {d[63], 31'd0};
    es  = int'(d[62:52]) - 1023 + 127;
    sig = {11'd0, 1'b1, d[51:0]};
    sh  = (es >= 1) ? 29 : 30 - es;
    if (sh > 60) return {d[63], 31'd0};
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (es >= 1) begin
      if (kept[24]) begin
        kept = kept >> 1;
        es   = es + 1;
      end
      if (es >= 255) return {d[63], INF_WORD[30:0]};
      return {d[63], 8'(es), kept[22:0]};
    end
    // A subnormal that rounds up to the smallest normal carries into the exponent.
    return {d[63], kept[30:0]};
  endfunction

  // Power of one bin: each square and the sum rounded on their own.
  function automatic logic [31:0] bin_power(input logic [31:0] re, input logic [31:0] im);
    real         a;
    real         b;
    logic [31:0] re_sq;
    logic [31:0] im_sq;
    a     = single_to_double(re);
    b     = single_to_double(im);
    re_sq = double_to_single(a * a);
    im_sq = double_to_single(b * b);
    return double_to_single(single_to_double(re_sq) + single_to_double(im_sq));
  endfunction

  // Operand drawn from one of several classes to reach the rounding corners.
  function automatic logic [31:0] rand_operand();
    logic [31:0] w;
    int          sel;
    w   = $urandom;
    sel = $urandom_range(0, 9);
    case (sel)
      4: w[30:23] = 8'($urandom_range(45, 70));    // squares near the subnormal range
      5: w[30:23] = 8'($urandom_range(180, 200));  // squares near overflow
      6: w[30:23] = 8'd0;                         // subnormal operand
      7: begin
        case ($urandom_range(0, 3))
          0: w[30:0] = 31'd0;
          1: w[30:0] = INF_WORD[30:0];
          default: w[30:23] = EXP_MAX;             // NaN, or infinity on a zero fraction
        endcase
      end
      8, 9: w[30:23] = 8'($urandom_range(100, 150));
      default: ;
    endcase
    return w;
  endfunction

  // Record the expected result of an accepted bin and step the frame counter.
  task automatic predict_bin(input logic [31:0] re, input logic [31:0] im,
                             input logic known, input logic [31:0] typed);
    power_word_t exp_word;
    if (bin_count < KEPT) begin
      exp_word.power_value = bin_power(re, im);
      exp_word.frame_end   = (bin_count == KEPT - 1);
      if (known && exp_word.power_value != typed) begin
        $error("power_value table entry: expected %h, predicted %h", typed,
               exp_word.power_value);
        error_count++;
      end
      if (known) exp_word.power_value = typed;
      power_queue.push_back(exp_word);
    end
    bin_count = (bin_count + 1 >= FRAME_LEN) ? 0 : bin_count + 1;
  endtask

  // Present one bin and hold it until the unit takes it.
  task automatic send_bin(input logic [31:0] re, input logic [31:0] im,
                          input logic known, input logic [31:0] typed);
    @(negedge clk);
    bin_valid = 1'b1;
    real_part = re;
    imag_part = im;
    do @(posedge clk); while (!bin_ready);
    predict_bin(re, im, known, typed);
  endtask

  task automatic idle_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      bin_valid = 1'b0;
      real_part = $urandom;
      imag_part = $urandom;
    end
  endtask

  // Result side stalls in stretches: always ready, random, mostly stalled, or mostly ready.
  always @(negedge clk) begin
    if (rst) begin
      power_ready <= 1'b0;
    end else begin
      case (($time / 800) % 4)
        0: power_ready <= 1'b1;
        1: power_ready <= ($urandom_range(0, 1) == 1);
        2: power_ready <= ($urandom_range(0, 5) == 0);
        default: power_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Compare each delivered power word with the oldest prediction.
  always @(posedge clk) begin
    power_word_t exp_word;
    if (!rst && power_valid && power_ready) begin
      if (power_queue.size() == 0) begin
        $error("power word %h with no bin pending", power_value);
        error_count++;
      end else begin
        exp_word = power_queue.pop_front();
        if (power_value !== exp_word.power_value) begin
          $error("power_value: expected %h, actual %h", exp_word.power_value, power_value);
          error_count++;
        end
        if (frame_end !== exp_word.frame_end) begin
          $error("frame_end: expected %b, actual %b", exp_word.frame_end, frame_end);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (bin_valid && bin_ready) || (power_valid && power_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bin_row_t table_rows[$];
    int       burst;
    int       sent;
    bin_row_t row;

    rst         = 1'b1;
    bin_valid   = 1'b0;
    real_part   = 32'd0;
    imag_part   = 32'd0;
    bin_count   = 0;
    error_count = 0;

    // Directed bins: zeros, signs, specials, overflow and underflow.
    table_rows = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000},
      '{32'h3F80_0000, 32'h0000_0000, 1'b1, 32'h3F80_0000},
      '{32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h4000_0000},
      '{32'hBF80_0000, 32'h4000_0000, 1'b1, 32'h40A0_0000},
      '{32'h7F80_0000, 32'h0000_0000, 1'b1, INF_WORD},
      '{32'hFF80_0000, 32'h3F80_0000, 1'b1, INF_WORD},
      '{32'h7FC0_0000, 32'h0000_0000, 1'b1, QNAN_WORD},
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, QNAN_WORD},
      '{32'h7F80_0001, 32'h7F80_0000, 1'b1, QNAN_WORD},
      '{32'h0000_0000, 32'hFFC0_0001, 1'b1, QNAN_WORD},
      '{32'h7F7F_FFFF, 32'h0000_0000, 1'b1, INF_WORD},
      '{32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b1, INF_WORD},
      '{32'h5F80_0000, 32'h5F80_0000, 1'b1, INF_WORD},
      '{32'h0000_0001, 32'h8000_0001, 1'b1, 32'h0000_0000},
      '{32'h0080_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{32'h1F80_0000, 32'h0000_0000, 1'b1, 32'h0020_0000},
      '{32'h1F80_0000, 32'h9F80_0000, 1'b1, 32'h0040_0000},
      '{32'h1A00_0001, 32'h1FFF_FFFF, 1'b0, 32'h0},
      '{32'h3FB5_04F3, 32'hBFB5_04F3, 1'b0, 32'h0},
      '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'h0},
      '{32'h5F7F_FFFF, 32'h5F7F_FFFF, 1'b0, 32'h0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_bin(row.re, row.im, row.known, row.power_value);
    end
    idle_gap(3);

    // Random bins in bursts separated by gaps, some of them back to back.
    sent = 0;
    while (sent < RAND_WORDS) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && sent < RAND_WORDS; k++) begin
        send_bin(rand_operand(), rand_operand(), 1'b0, 32'h0);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
    end
    idle_gap(1);

    while (power_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
